// File: design/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types, phase and gesture codes, and register indexes for the
// button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned ElapW   = 10;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned GestW   = 4;

  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HOLD     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DBL      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ENABLE   = 3'd4;

  localparam logic [PhaseW-1:0] PH_REST      = 4'd0;
  localparam logic [PhaseW-1:0] PH_DOWN1_DB  = 4'd1;
  localparam logic [PhaseW-1:0] PH_DOWN1     = 4'd2;
  localparam logic [PhaseW-1:0] PH_HOLD      = 4'd3;
  localparam logic [PhaseW-1:0] PH_UP1_DB    = 4'd4;
  localparam logic [PhaseW-1:0] PH_UP1       = 4'd5;
  localparam logic [PhaseW-1:0] PH_PRESS1_DB = 4'd6;
  localparam logic [PhaseW-1:0] PH_DOWN2_DB  = 4'd7;
  localparam logic [PhaseW-1:0] PH_DOWN2     = 4'd8;
  localparam logic [PhaseW-1:0] PH_UP2_DB    = 4'd9;
  localparam logic [PhaseW-1:0] PH_PRESS2_DB = 4'd10;
  localparam logic [PhaseW-1:0] PH_LAST_DB   = 4'd11;

  localparam logic [GestW-1:0] G_NONE        = 4'd0;
  localparam logic [GestW-1:0] G_DOWN        = 4'd1;
  localparam logic [GestW-1:0] G_HOLD        = 4'd2;
  localparam logic [GestW-1:0] G_UP          = 4'd3;
  localparam logic [GestW-1:0] G_CLICK       = 4'd4;
  localparam logic [GestW-1:0] G_PRESS       = 4'd5;
  localparam logic [GestW-1:0] G_CLICK_HOLD  = 4'd6;
  localparam logic [GestW-1:0] G_DBL_CLICK   = 4'd7;
  localparam logic [GestW-1:0] G_CLICK_PRESS = 4'd8;

  typedef struct packed {
    logic             button_level;
    logic [ElapW-1:0] elapsed;
  } in_beat_t;

  typedef struct packed {
    logic [GestW-1:0] gesture;
    logic             also_up;
  } out_beat_t;

  typedef struct packed {
    logic [TimerW-1:0] debounce_time;
    logic [TimerW-1:0] hold_time;
    logic [TimerW-1:0] press_time;
    logic [TimerW-1:0] double_click_time;
    logic              enable_reporting;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

// File: design/bgd_cfg.sv
// ----------------------------------------------------------------------------
// bgd_cfg
// Configuration register file with reset defaults.
// ----------------------------------------------------------------------------
module bgd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bgd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bgd_pkg::CfgW-1:0]    cfg_data,
  output bgd_pkg::cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time     <= 16'd20;
      cfg.hold_time         <= 16'd1000;
      cfg.press_time        <= 16'd300;
      cfg.double_click_time <= 16'd250;
      cfg.enable_reporting  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        bgd_pkg::REG_DEBOUNCE: cfg.debounce_time     <= cfg_data;
        bgd_pkg::REG_HOLD:     cfg.hold_time         <= cfg_data;
        bgd_pkg::REG_PRESS:    cfg.press_time        <= cfg_data;
        bgd_pkg::REG_DBL:      cfg.double_click_time <= cfg_data;
        bgd_pkg::REG_ENABLE:   cfg.enable_reporting  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/bgd_core.sv
// ----------------------------------------------------------------------------
// bgd_core
// Input register, phase/timer state and the one-pass gesture decision.
// ----------------------------------------------------------------------------
module bgd_core (
  input  logic                 clk,
  input  logic                 rst,
  input  bgd_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bgd_pkg::in_beat_t    in_data,
  output bgd_pkg::stage_ctl_t  ctl_up,
  input  bgd_pkg::stage_ctl_t  ctl_dn,
  output bgd_pkg::out_beat_t   res
);

  logic                        s1_valid;
  bgd_pkg::in_beat_t           s1_data;
  logic [bgd_pkg::PhaseW-1:0]  phase;
  logic [bgd_pkg::PhaseW-1:0]  phase_next;
  logic [bgd_pkg::TimerW-1:0]  timer;
  logic [bgd_pkg::TimerW-1:0]  timer_next;
  logic [bgd_pkg::TimerW:0]    sum;
  logic [bgd_pkg::TimerW-1:0]  adv;
  logic [bgd_pkg::GestW-1:0]   g;
  logic                        high;
  logic                        take;

  assign take     = ctl_dn.take;
  assign in_stall = s1_valid && !take;
  assign ctl_up   = '{valid: s1_valid, take: 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bgd_pkg::PH_REST;
      timer <= '0;
    end else if (take) begin
      phase <= phase_next;
      timer <= timer_next;
    end
  end

  assign high = s1_data.button_level;
  assign sum  = {1'b0, timer} + {{(bgd_pkg::TimerW + 1 - bgd_pkg::ElapW){1'b0}}, s1_data.elapsed};
  assign adv  = sum[bgd_pkg::TimerW] ? {bgd_pkg::TimerW{1'b1}} : sum[bgd_pkg::TimerW-1:0];

  always_comb begin
    phase_next = phase;
    timer_next = timer;
    g          = bgd_pkg::G_NONE;
    case (phase)
      bgd_pkg::PH_DOWN1_DB, bgd_pkg::PH_DOWN2_DB: begin
        timer_next = adv;
        if (adv >= cfg.debounce_time) begin
          if (high) begin
            phase_next = (phase == bgd_pkg::PH_DOWN1_DB) ? bgd_pkg::PH_DOWN1
                                                          : bgd_pkg::PH_DOWN2;
            timer_next = '0;
            g          = bgd_pkg::G_DOWN;
          end else begin
            phase_next = bgd_pkg::PH_REST;
          end
        end
      end
      bgd_pkg::PH_DOWN1, bgd_pkg::PH_DOWN2: begin
        timer_next = adv;
        if (adv >= cfg.hold_time) begin
          phase_next = bgd_pkg::PH_HOLD;
          g = (phase == bgd_pkg::PH_DOWN1) ? bgd_pkg::G_HOLD : bgd_pkg::G_CLICK_HOLD;
        end else if (!high) begin
          timer_next = '0;
          if (phase == bgd_pkg::PH_DOWN1) begin
            phase_next = (adv < cfg.press_time) ? bgd_pkg::PH_UP1_DB
                                                : bgd_pkg::PH_PRESS1_DB;
          end else begin
            phase_next = (adv < cfg.press_time) ? bgd_pkg::PH_UP2_DB
                                                : bgd_pkg::PH_PRESS2_DB;
          end
        end
      end
      bgd_pkg::PH_HOLD: begin
        if (!high) begin
          phase_next = bgd_pkg::PH_LAST_DB;
          timer_next = '0;
        end
      end
      bgd_pkg::PH_UP1_DB: begin
        timer_next = adv;
        if (adv >= cfg.debounce_time) begin
          if (!high) begin
            phase_next = bgd_pkg::PH_UP1;
            timer_next = '0;
            g          = bgd_pkg::G_UP;
          end else begin
            phase_next = bgd_pkg::PH_REST;
          end
        end
      end
      bgd_pkg::PH_UP1: begin
        timer_next = adv;
        if (high) begin
          phase_next = bgd_pkg::PH_DOWN2_DB;
          timer_next = '0;
        end else if (adv >= cfg.double_click_time) begin
          phase_next = bgd_pkg::PH_REST;
          g          = bgd_pkg::G_CLICK;
        end
      end
      bgd_pkg::PH_PRESS1_DB, bgd_pkg::PH_UP2_DB, bgd_pkg::PH_PRESS2_DB: begin
        // timer is kept on exit
        timer_next = adv;
        if (adv >= cfg.debounce_time) begin
          phase_next = bgd_pkg::PH_REST;
          if (!high) begin
            case (phase)
              bgd_pkg::PH_PRESS1_DB: g = bgd_pkg::G_PRESS;
              bgd_pkg::PH_UP2_DB:    g = bgd_pkg::G_DBL_CLICK;
              default:               g = bgd_pkg::G_CLICK_PRESS;
            endcase
          end
        end
      end
      bgd_pkg::PH_LAST_DB: begin
        timer_next = adv;
        if (adv >= cfg.debounce_time && !high) begin
          phase_next = bgd_pkg::PH_REST;
          timer_next = '0;
          g          = bgd_pkg::G_UP;
        end
      end
      default: begin
        phase_next = bgd_pkg::PH_REST;
        if (high) begin
          phase_next = bgd_pkg::PH_DOWN1_DB;
          timer_next = '0;
        end
      end
    endcase
  end

  always_comb begin
    res.gesture = cfg.enable_reporting ? g : bgd_pkg::G_NONE;
    res.also_up = (res.gesture == bgd_pkg::G_PRESS) ||
                  (res.gesture == bgd_pkg::G_CLICK_PRESS);
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= bgd_pkg::PH_LAST_DB)
    else $error("phase left the used code range");

  a_state_held: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(phase) && $stable(timer))
    else $error("state moved without a beat");

  a_hold_stays: assert property (@(posedge clk) disable iff (rst)
    take && phase == bgd_pkg::PH_HOLD && high |=> phase == bgd_pkg::PH_HOLD)
    else $error("hold phase left while still pressed");

endmodule

// File: design/bgd_out.sv
// ----------------------------------------------------------------------------
// bgd_out
// Result register; decides when the decision stage moves forward.
// ----------------------------------------------------------------------------
module bgd_out (
  input  logic                 clk,
  input  logic                 rst,
  input  bgd_pkg::stage_ctl_t  ctl_up,
  output bgd_pkg::stage_ctl_t  ctl_dn,
  input  bgd_pkg::out_beat_t   res,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bgd_pkg::out_beat_t   out_data
);

  logic take;

  assign take   = ctl_up.valid && (!out_valid || !out_stall);
  assign ctl_dn = '{valid: out_valid, take: take};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= ctl_up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= res;
    end
  end

  a_also_up: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.also_up |->
      (out_data.gesture == bgd_pkg::G_PRESS || out_data.gesture == bgd_pkg::G_CLICK_PRESS))
    else $error("also_up without a press gesture");

endmodule

// File: design/button_gesture_detector.sv
// ----------------------------------------------------------------------------
// button_gesture_detector
// An accepted beat passes the input register, then the result register.
// Throughput: one tick per cycle unless out_stall holds the output; phase and
// timer update in a single pass between the input and result registers.
// Reset (rst, synchronous): registers to defaults, phase to rest, timer to 0.
// ----------------------------------------------------------------------------
module button_gesture_detector (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bgd_pkg::in_beat_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bgd_pkg::out_beat_t          out_data,
  input  logic                        cfg_we,
  input  logic [bgd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bgd_pkg::CfgW-1:0]    cfg_data
);

  bgd_pkg::cfg_t       cfg;
  bgd_pkg::stage_ctl_t ctl_up;
  bgd_pkg::stage_ctl_t ctl_dn;
  bgd_pkg::out_beat_t  res;

  bgd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bgd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .ctl_up   (ctl_up),
    .ctl_dn   (ctl_dn),
    .res      (res)
  );

  bgd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl_up    (ctl_up),
    .ctl_dn    (ctl_dn),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
